FILE: sv/bcd_decimal_alu_assert.svh
// Assertion macros shared by the checker of the decimal arithmetic unit.
`ifndef BCD_DECIMAL_ALU_ASSERT_SVH
`define BCD_DECIMAL_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define BDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define BDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bda_pkg.sv
// Types, codes and constants shared by the decimal arithmetic unit.
`default_nettype none
package bda_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_NEGATIVE = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] a_digits;
    logic [63:0] b_digits;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_digits;
    logic [2:0]  status;
    logic        a_less;
    logic        a_equal;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADDSUB,
    CMD_MSHIFT,
    CMD_MADD,
    CMD_DSHIFT,
    CMD_DSUB
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADDSUB,
    S_MSHIFT,
    S_MADD,
    S_DSHIFT,
    S_DSUB,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic       invalid;
    logic       b_zero;
    logic [2:0] op;
    logic       rep_zero;
    logic       cnt_done;
    logic       ge;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/bda_dp.sv
// Datapath of the decimal arithmetic unit: operand registers and a BCD adder.
`default_nettype none
module bda_dp #(
  parameter int unsigned DIGITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire bda_pkg::cmd_e       cmd_i,
  input  wire bda_pkg::in_word_t   in_word_i,
  output bda_pkg::dp_status_t      status_o,
  output bda_pkg::out_word_t       result_o
);
  import bda_pkg::*;

  localparam int unsigned W  = 4 * DIGITS;
  localparam int unsigned DW = W + 4;
  localparam int unsigned CW = $clog2(DIGITS + 1);

  logic [2:0]    op_q;
  logic [W-1:0]  a_q, b_q, quo_q;
  logic [DW-1:0] acc_q;
  logic [3:0]    rep_q;
  logic [CW-1:0] cnt_q;
  logic          ovf_q, invalid_q, less_q, equal_q, bzero_q;

  logic [W-1:0]  in_a, in_b;
  logic          in_invalid;
  logic [DW-1:0] b_ext;
  logic [DW-1:0] add_x, add_y, b_comp, add_sum;
  logic          add_cin;
  logic [DW:0]   t1, t2, t3, t4, corr;
  logic [2:0]    st;
  logic [W-1:0]  res;

  assign in_a  = in_word_i.a_digits[W-1:0];
  assign in_b  = in_word_i.b_digits[W-1:0];
  assign b_ext = {4'b0, b_q};

  always_comb begin
    in_invalid = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      if (in_a[4*k+3] && (in_a[4*k+2] || in_a[4*k+1])) in_invalid = 1'b1;
      if (in_b[4*k+3] && (in_b[4*k+2] || in_b[4*k+1])) in_invalid = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS + 1; k++) begin
      b_comp[4*k +: 4] = 4'd9 - b_ext[4*k +: 4];
    end
  end

  always_comb begin
    case (cmd_i)
      CMD_ADDSUB: begin
        add_x   = {4'b0, a_q};
        add_y   = (op_q == OP_SUB) ? b_comp : {4'b0, b_q};
        add_cin = (op_q == OP_SUB);
      end
      CMD_DSUB: begin
        add_x   = acc_q;
        add_y   = b_comp;
        add_cin = 1'b1;
      end
      default: begin
        add_x   = acc_q;
        add_y   = {4'b0, a_q};
        add_cin = 1'b0;
      end
    endcase
  end

  always_comb begin
    t1 = {1'b0, add_x} + {1'b0, {(DIGITS + 1){4'h6}}};
    t2 = t1 + {1'b0, add_y} + {{DW{1'b0}}, add_cin};
    t3 = t1 ^ {1'b0, add_y};
    t4 = t2 ^ t3;
    corr = '0;
    for (int k = 0; k < DIGITS + 1; k++) begin
      corr[4*k +: 4] = t4[4*k+4] ? 4'd0 : 4'd6;
    end
    add_sum = t2[DW-1:0] - corr[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_ADD;
      a_q       <= '0;
      b_q       <= '0;
      quo_q     <= '0;
      acc_q     <= '0;
      rep_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      invalid_q <= 1'b0;
      less_q    <= 1'b0;
      equal_q   <= 1'b0;
      bzero_q   <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_LOAD: begin
          op_q      <= in_word_i.req_type;
          a_q       <= in_a;
          b_q       <= in_b;
          quo_q     <= '0;
          acc_q     <= '0;
          rep_q     <= '0;
          cnt_q     <= '0;
          ovf_q     <= 1'b0;
          invalid_q <= in_invalid;
          less_q    <= in_a < in_b;
          equal_q   <= in_a == in_b;
          bzero_q   <= in_b == '0;
        end
        CMD_ADDSUB: begin
          acc_q <= {4'b0, add_sum[W-1:0]};
          ovf_q <= add_sum[DW-1:W] != 4'd0;
        end
        CMD_MSHIFT: begin
          ovf_q <= ovf_q || (acc_q[W-1 -: 4] != 4'd0);
          acc_q <= {4'b0, acc_q[W-1:0] << 4};
          rep_q <= b_q[W-1 -: 4];
          b_q   <= b_q << 4;
          cnt_q <= cnt_q + CW'(1);
        end
        CMD_MADD: begin
          ovf_q <= ovf_q || (add_sum[DW-1:W] != 4'd0);
          acc_q <= {4'b0, add_sum[W-1:0]};
          rep_q <= rep_q - 4'd1;
        end
        CMD_DSHIFT: begin
          acc_q <= {acc_q[DW-5:0], a_q[W-1 -: 4]};
          a_q   <= a_q << 4;
          quo_q <= quo_q << 4;
          cnt_q <= cnt_q + CW'(1);
        end
        CMD_DSUB: begin
          acc_q <= add_sum;
          quo_q <= quo_q + W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st = ST_OK;
    if (invalid_q) begin
      st = ST_INVALID;
    end else begin
      case (op_q)
        OP_ADD: if (ovf_q) st = ST_OVERFLOW;
        OP_SUB: if (less_q) st = ST_NEGATIVE;
        OP_MUL: if (ovf_q) st = ST_OVERFLOW;
        OP_DIV, OP_REM: if (bzero_q) st = ST_DIVZERO;
        default: st = ST_OK;
      endcase
    end
    case (op_q)
      OP_DIV: res = quo_q;
      OP_ADD, OP_SUB, OP_MUL, OP_REM: res = acc_q[W-1:0];
      default: res = '0;
    endcase
    if (st != ST_OK) res = '0;
  end

  assign result_o.result_digits = 64'(res);
  assign result_o.status        = st;
  assign result_o.a_less        = less_q && !invalid_q;
  assign result_o.a_equal       = equal_q && !invalid_q;

  assign status_o.invalid  = invalid_q;
  assign status_o.b_zero   = bzero_q;
  assign status_o.op       = op_q;
  assign status_o.rep_zero = rep_q == 4'd0;
  assign status_o.cnt_done = cnt_q == CW'(DIGITS);
  assign status_o.ge       = acc_q >= {4'b0, b_q};

endmodule
`default_nettype wire

FILE: sv/bda_ctrl.sv
// Controller state machine that sequences the decimal arithmetic datapath.
`default_nettype none
module bda_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire                      out_free_i,
  input  wire bda_pkg::dp_status_t status_i,
  output bda_pkg::cmd_e            cmd_o,
  output logic                     emit_o
);
  import bda_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    emit_o     = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.invalid) begin
          state_d = S_FINISH;
        end else begin
          case (status_i.op)
            OP_ADD, OP_SUB: state_d = S_ADDSUB;
            OP_MUL: state_d = S_MSHIFT;
            OP_DIV, OP_REM: state_d = status_i.b_zero ? S_FINISH : S_DSHIFT;
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_ADDSUB: begin
        cmd_o   = CMD_ADDSUB;
        state_d = S_FINISH;
      end
      S_MSHIFT: begin
        cmd_o   = CMD_MSHIFT;
        state_d = S_MADD;
      end
      S_MADD: begin
        if (!status_i.rep_zero) begin
          cmd_o = CMD_MADD;
        end else begin
          state_d = status_i.cnt_done ? S_FINISH : S_MSHIFT;
        end
      end
      S_DSHIFT: begin
        cmd_o   = CMD_DSHIFT;
        state_d = S_DSUB;
      end
      S_DSUB: begin
        if (status_i.ge) begin
          cmd_o = CMD_DSUB;
        end else begin
          state_d = status_i.cnt_done ? S_FINISH : S_DSHIFT;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/bcd_decimal_alu.sv
// Top level of the decimal arithmetic unit for packed BCD operands.
// One word at a time: add and subtract take a single BCD addition per word.
// Multiply and divide step one digit at a time with up to nine additions or subtractions per digit.
// The result sits in an output register, so the next word may be accepted while it waits.
// Reset clears the controller, the datapath registers and the output valid.
`default_nettype none
module bcd_decimal_alu #(
  parameter int unsigned DIGITS = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire bda_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output bda_pkg::out_word_t      out_word_o
);
  import bda_pkg::*;

  cmd_e       cmd;
  dp_status_t dp_status;
  out_word_t  dp_result;
  logic       emit, out_free;
  logic       out_valid_q;
  out_word_t  out_word_q;

  assign out_free = !out_valid_q || !out_stall_i;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (dp_status),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  bda_dp #(.DIGITS(DIGITS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .status_o  (dp_status),
    .result_o  (dp_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
      out_word_q  <= dp_result;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

FILE: sv/bda_checker.sv
// Port-level checker for the decimal arithmetic unit and its bind.
`default_nettype none
`include "bcd_decimal_alu_assert.svh"
module bda_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_stall_o,
  input wire                     out_valid_o,
  input wire                     out_stall_i,
  input wire bda_pkg::out_word_t out_word_o
);
  import bda_pkg::*;

  `BDA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `BDA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `BDA_ASSERT_IMP(a_invalid_zero,
    out_valid_o && (out_word_o.status == ST_INVALID),
    (out_word_o.result_digits == 64'd0) && !out_word_o.a_less && !out_word_o.a_equal)
  `BDA_ASSERT_IMP(a_flags_excl, out_valid_o, !(out_word_o.a_less && out_word_o.a_equal))
  `BDA_ASSERT_IMP(a_neg_less,
    out_valid_o && (out_word_o.status == ST_NEGATIVE),
    out_word_o.a_less && (out_word_o.result_digits == 64'd0))

endmodule

bind bcd_decimal_alu bda_checker u_bda_checker (.*);
`default_nettype wire

FILE: test/tb_bcd_decimal_alu.sv
// Self-checking testbench for the decimal arithmetic unit with random stimulus and stalls.
`default_nettype none
module tb_bcd_decimal_alu;
  import bda_pkg::*;

  localparam int unsigned DIGITS = 16;
  localparam logic [2:0] OP_CMP = 3'd5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  out_word_t expected_words[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int op_seen[8];
  int stall_left = 0;
  bit hold_off = 1'b0;
  bit no_gaps = 1'b0;

  bcd_decimal_alu #(.DIGITS(DIGITS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit decode_bcd(input logic [63:0] bcd, output logic [63:0] val);
    logic [63:0] v;
    v = 0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (bcd[4*i +: 4] > 4'd9) return 1'b0;
      v = v * 10 + bcd[4*i +: 4];
    end
    val = v;
    return 1'b1;
  endfunction

  function automatic logic [63:0] encode_bcd(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic out_word_t decimal_result(input in_word_t w);
    out_word_t o;
    logic [63:0] a, b, lim, r;
    logic [2:0] st;
    o = '0;
    if (!decode_bcd(w.a_digits, a) || !decode_bcd(w.b_digits, b)) begin
      o.status = ST_INVALID;
      return o;
    end
    lim = 1;
    for (int i = 0; i < DIGITS; i++) lim = lim * 10;
    r = 0;
    st = ST_OK;
    case (w.req_type)
      OP_ADD: begin
        r = a + b;
        if (r >= lim) st = ST_OVERFLOW;
      end
      OP_SUB: begin
        if (a < b) st = ST_NEGATIVE;
        else r = a - b;
      end
      OP_MUL: begin
        if (b != 0 && a > (lim - 1) / b) st = ST_OVERFLOW;
        else r = a * b;
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIVZERO;
        else r = a / b;
      end
      OP_REM: begin
        if (b == 0) st = ST_DIVZERO;
        else r = a % b;
      end
      default: r = 0;
    endcase
    o.result_digits = (st == ST_OK) ? encode_bcd(r) : '0;
    o.status = st;
    o.a_less = a < b;
    o.a_equal = a == b;
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Random BCD value with a random number of significant digits.
  function automatic logic [63:0] random_bcd(input int max_len);
    logic [63:0] v;
    int len;
    v = '0;
    len = $urandom_range(max_len);
    for (int i = 0; i < len; i++) v[4*i +: 4] = 4'($urandom_range(9));
    return v;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word_i <= '{req_type: op, a_digits: a, b_digits: b};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(decimal_result('{req_type: op, a_digits: a, b_digits: b}));
    words_sent++;
    op_seen[op]++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (no_gaps) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < 20) begin
      out_stall_i <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h", out_word_o);
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (out_word_o.result_digits !== exp_w.result_digits ||
            out_word_o.status !== exp_w.status ||
            out_word_o.a_less !== exp_w.a_less ||
            out_word_o.a_equal !== exp_w.a_equal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
                     exp_w.result_digits, exp_w.status, exp_w.a_less, exp_w.a_equal,
                     out_word_o.result_digits, out_word_o.status, out_word_o.a_less,
                     out_word_o.a_equal);
        end
      end
    end
  end

  task automatic test_directed();
    logic [63:0] all9;
    all9 = {16{4'h9}};
    for (int op = 0; op < 8; op++) send_word(op[2:0], 64'h123, 64'h45);
    send_word(OP_ADD, all9, 64'h1);
    send_word(OP_ADD, all9, 64'h0);
    send_word(OP_SUB, 64'h5, 64'h7);
    send_word(OP_SUB, all9, all9);
    send_word(OP_MUL, all9, 64'h2);
    send_word(OP_MUL, 64'h9999_9999, 64'h9999_9999);
    send_word(OP_MUL, all9, 64'h0);
    send_word(OP_DIV, all9, 64'h0);
    send_word(OP_REM, 64'h77, 64'h0);
    send_word(OP_DIV, all9, 64'h1);
    send_word(OP_REM, all9, 64'h7);
    send_word(OP_CMP, 64'h0, 64'h0);
    send_word(OP_ADD, 64'hA, 64'h1);
    send_word(OP_DIV, 64'h1, {4'hF, 60'h0});
    send_word(OP_CMP, {16{4'hF}}, {16{4'hF}});
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [2:0] op;
    logic [63:0] a, b;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(99) < 94 ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
      a = random_bcd(16);
      b = (op == OP_MUL || op == OP_DIV || op == OP_REM) && $urandom_range(1)
          ? random_bcd(8) : random_bcd(16);
      if ($urandom_range(99) < 4) b = '0;
      if ($urandom_range(99) < 4) a = b;
      if ($urandom_range(99) < 5) begin
        if ($urandom_range(1)) a = {$urandom, $urandom};
        else b = {$urandom, $urandom};
      end
      send_word(op, a, b);
    end
  endtask

  // The receiver holds off while the sender keeps offering words back to back.
  task automatic test_backpressure();
    int held;
    hold_off = 1'b1;
    no_gaps = 1'b1;
    fork
      test_random(12);
      begin
        held = 0;
        while (held < 1500) begin
          @(negedge clk_i);
          held++;
        end
        hold_off = 1'b0;
      end
    join
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_full_rate();
    no_gaps = 1'b1;
    test_random(150);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(800);
    wait_drained();
    test_full_rate();
    test_random(900);
    wait_drained();
    repeat (400) @(negedge clk_i);
    $display("Sent %0d words, checked %0d results, %0d mismatches.",
             words_sent, words_checked, mismatches);
    $display("Ops add %0d sub %0d mul %0d div %0d rem %0d cmp %0d unused %0d.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6] + op_seen[7]);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
